>>> design/dqvd_pkg.sv
// shared types and codes for the value-delete deque
package dqvd_pkg;

	// command codes
	localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
	localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
	localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
	localparam logic [3:0] CMD_POP_BACK   = 4'd3;
	localparam logic [3:0] CMD_CLEAR      = 4'd4;
	localparam logic [3:0] CMD_DELETE     = 4'd5;
	localparam logic [3:0] CMD_READ_ALL   = 4'd6;
	localparam logic [3:0] CMD_READ_FIRST = 4'd7;
	localparam logic [3:0] CMD_READ_LAST  = 4'd8;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// most items one read returns
	localparam int unsigned RESULT_CAP = 32;

	// what every cell does in a cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_SHIFT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [31:0] din;
	} cell_ctl_t;

endpackage

>>> design/dqvd_cell.sv
// one storage cell of the deque chain
module dqvd_cell (
	input  logic               clk,
	input  dqvd_pkg::cell_ctl_t ctl,
	input  logic [31:0]        prev_d,
	input  logic [31:0]        next_d,
	input  logic [31:0]        head_d,
	input  logic               is_fill,
	input  logic               is_tail,
	output logic [31:0]        data
);
	import dqvd_pkg::*;

	logic [31:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_PUSH_FRONT: data_q <= prev_d;
			CELL_PUSH_BACK: begin
				if (is_fill) begin
					data_q <= ctl.din;
				end
			end
			CELL_SHIFT: data_q <= next_d;
			// tail cell closes the ring by taking the head
			CELL_ROTATE: data_q <= is_tail ? head_d : next_d;
			default: data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

>>> design/deque_with_value_delete.sv
// deque of signed 32-bit values with delete-by-value, built as a chain of cells
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------
//  input   | in_valid  | in_stall  | cmd, operand
//  output  | out_valid | out_stall | value, has_value, status, last
//
// push, pop, clear and unused commands give one item each.
// delete on a non-empty queue and reads with a non-empty selection rotate the
// whole chain once through cell 0, one step per element stored at the start.
// a held output stalls the rotation only on cycles that must emit an item.
// reset empties the queue; cell contents are not reset.
// in_stall is high while a rotation runs or the output register is stalled.
module deque_with_value_delete #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         cmd,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic               has_value,
	output logic [1:0]         status,
	output logic               last
);
	import dqvd_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_ROTATE
	} state_t;

	typedef enum logic {
		MODE_DELETE,
		MODE_READ
	} mode_t;

	// control state
	state_t           state_q;
	mode_t            mode_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] steps_q;   // rotation length, element count at start
	logic [CNT_W-1:0] step_q;    // current rotation step
	logic [CNT_W-1:0] win_lo_q;  // first step that emits
	logic [CNT_W-1:0] win_hi_q;  // one past the last step that emits
	logic             found_q;
	logic [31:0]      key_q;

	// output register
	logic             out_valid_q;
	logic [31:0]      value_q;
	logic             has_value_q;
	logic [1:0]       status_q;
	logic             last_q;

	// cell chain
	cell_ctl_t   cell_ctl;
	logic [31:0] cell_data [DEPTH];
	logic [31:0] head;

	// next-state terms
	state_t           state_d;
	mode_t            mode_d;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] steps_d;
	logic [CNT_W-1:0] step_d;
	logic [CNT_W-1:0] win_lo_d;
	logic [CNT_W-1:0] win_hi_d;
	logic             found_d;
	logic [31:0]      key_d;
	logic             load_out;
	logic [31:0]      o_value;
	logic             o_has;
	logic [1:0]       o_status;
	logic             o_last;

	logic             out_free;
	logic             accept;
	logic [CNT_W-1:0] clamp_n;
	logic [CNT_W-1:0] sel_n;
	logic [CNT_W-1:0] cap_n;
	logic [CNT_W-1:0] lo_n;
	logic             emit_now;
	logic             final_step;
	logic             head_match;
	logic             need_out;

	assign head = cell_data[0];

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [31:0] prev_w;
			logic [31:0] next_w;
			if (gi == 0) begin : g_first
				assign prev_w = cell_ctl.din;
			end else begin : g_mid
				assign prev_w = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_end
				assign next_w = head;
			end else begin : g_inner
				assign next_w = cell_data[gi+1];
			end
			dqvd_cell u_cell (
				.clk     (clk),
				.ctl     (cell_ctl),
				.prev_d  (prev_w),
				.next_d  (next_w),
				.head_d  (head),
				.is_fill (count_q == CNT_W'(gi)),
				.is_tail (count_q == CNT_W'(gi + 1)),
				.data    (cell_data[gi])
			);
		end
	endgenerate

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		in_stall = (state_q != S_IDLE) || !out_free;
		accept   = in_valid && !in_stall;

		// read selection: negative counts as zero, capped at the element count
		if (operand[31]) begin
			clamp_n = '0;
		end else if ($unsigned(operand) > 32'(count_q)) begin
			clamp_n = count_q;
		end else begin
			clamp_n = operand[CNT_W-1:0];
		end
		sel_n = (cmd == CMD_READ_ALL) ? count_q : clamp_n;
		cap_n = (32'(sel_n) > RESULT_CAP) ? CNT_W'(RESULT_CAP) : sel_n;
		lo_n  = (cmd == CMD_READ_LAST) ? (count_q - sel_n) : '0;

		emit_now   = (mode_q == MODE_READ) && (step_q >= win_lo_q) && (step_q < win_hi_q);
		final_step = (step_q == steps_q - CNT_W'(1));
		head_match = !found_q && (head == key_q);
		need_out   = emit_now || ((mode_q == MODE_DELETE) && final_step);

		cell_ctl.op  = CELL_HOLD;
		cell_ctl.din = operand;
		state_d  = state_q;
		mode_d   = mode_q;
		count_d  = count_q;
		steps_d  = steps_q;
		step_d   = step_q;
		win_lo_d = win_lo_q;
		win_hi_d = win_hi_q;
		found_d  = found_q;
		key_d    = key_q;
		load_out = 1'b0;
		o_value  = '0;
		o_has    = 1'b0;
		o_status = ST_OK;
		o_last   = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load_out = 1'b1;
					case (cmd)
						CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
							if (count_q == CNT_W'(DEPTH)) begin
								o_status = ST_FULL;
							end else begin
								cell_ctl.op = (cmd == CMD_PUSH_FRONT) ? CELL_PUSH_FRONT
								                                      : CELL_PUSH_BACK;
								count_d = count_q + CNT_W'(1);
							end
						end
						CMD_POP_FRONT, CMD_POP_BACK: begin
							if (count_q == '0) begin
								o_status = ST_EMPTY;
							end else begin
								if (cmd == CMD_POP_FRONT) begin
									cell_ctl.op = CELL_SHIFT;
								end
								count_d = count_q - CNT_W'(1);
							end
						end
						CMD_CLEAR: count_d = '0;
						CMD_DELETE: begin
							if (count_q == '0) begin
								o_status = ST_NOTFOUND;
							end else begin
								// result comes at the end of the rotation
								load_out = 1'b0;
								state_d  = S_ROTATE;
								mode_d   = MODE_DELETE;
								steps_d  = count_q;
								step_d   = '0;
								found_d  = 1'b0;
								key_d    = operand;
							end
						end
						CMD_READ_ALL, CMD_READ_FIRST, CMD_READ_LAST: begin
							// empty selection gives the single no-value item
							if (cap_n != '0) begin
								load_out = 1'b0;
								state_d  = S_ROTATE;
								mode_d   = MODE_READ;
								steps_d  = count_q;
								step_d   = '0;
								win_lo_d = lo_n;
								win_hi_d = lo_n + cap_n;
							end
						end
						default: ;
					endcase
				end
			end
			S_ROTATE: begin
				if (out_free || !need_out) begin
					step_d = step_q + CNT_W'(1);
					if ((mode_q == MODE_DELETE) && head_match) begin
						// drop the head instead of wrapping it
						cell_ctl.op = CELL_SHIFT;
						count_d     = count_q - CNT_W'(1);
						found_d     = 1'b1;
					end else begin
						cell_ctl.op = CELL_ROTATE;
					end
					if (emit_now) begin
						load_out = 1'b1;
						o_value  = head;
						o_has    = 1'b1;
						o_last   = (step_q == win_hi_q - CNT_W'(1));
					end
					if (final_step) begin
						state_d = S_IDLE;
						if (mode_q == MODE_DELETE) begin
							load_out = 1'b1;
							o_status = (found_q || head_match) ? ST_OK : ST_NOTFOUND;
						end
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_READ;
			count_q     <= '0;
			steps_q     <= '0;
			step_q      <= '0;
			win_lo_q    <= '0;
			win_hi_q    <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mode_q   <= mode_d;
			count_q  <= count_d;
			steps_q  <= steps_d;
			step_q   <= step_d;
			win_lo_q <= win_lo_d;
			win_hi_q <= win_hi_d;
			found_q  <= found_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		key_q <= key_d;
		if (load_out) begin
			value_q     <= o_value;
			has_value_q <= o_has;
			status_q    <= o_status;
			last_q      <= o_last;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign has_value = has_value_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

>>> design/dqvd_checker.sv
// port-level checks for the value-delete deque, bound to the top level
module dqvd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [3:0]         cmd,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] value,
	input logic               has_value,
	input logic [1:0]         status,
	input logic               last
);
	import dqvd_pkg::*;

	// an item without a value carries zero and ends its command
	a_novalue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_value |-> (value == 0) && last)
		else $error("no-value item not zero or not last");

	// element items are always read results with status ok
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_value |-> status == ST_OK)
		else $error("element item with bad status");

	// push, pop, clear and unused commands show their result on the next cycle
	a_simple_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd != CMD_DELETE) && (cmd != CMD_READ_ALL) &&
		(cmd != CMD_READ_FIRST) && (cmd != CMD_READ_LAST) |=> out_valid)
		else $error("simple command gave no item");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(status) &&
		$stable(last) && $stable(has_value))
		else $error("stalled output item changed");

endmodule

bind deque_with_value_delete dqvd_checker u_dqvd_checker (.*);
